@@ src/i2cseq_pkg.sv @@
package i2cseq_pkg;

	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

	// request codes
	localparam logic [1:0] REQ_START_TX = 2'd0;
	localparam logic [1:0] REQ_START_RX = 2'd1;
	localparam logic [1:0] REQ_EVENT    = 2'd2;

	// completion codes
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_TX_DONE = 2'd1;
	localparam logic [1:0] EV_RX_DONE = 2'd2;
	localparam logic [1:0] EV_STOPF   = 2'd3;

	typedef enum logic [1:0] {
		ST_READY = 2'd0,
		ST_TX    = 2'd1,
		ST_RX    = 2'd2
	} xfer_state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] dev_address;
		logic [7:0] xfer_length;
		logic       repeated_start;
		logic       flag_sb;
		logic       flag_addr;
		logic       flag_btf;
		logic       flag_txe;
		logic       flag_rxne;
		logic       flag_stopf;
		logic       master_mode;
		logic [7:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0] prev_status;
		logic       start_cmd;
		logic       stop_cmd;
		logic       dr_write_valid;
		logic [7:0] dr_write_value;
		logic       rx_valid;
		logic [7:0] rx_value;
		logic       ack_bit;
		logic [1:0] event_code;
		logic       last;
	} out_item_t;

	// sequencer context carried between requests
	typedef struct packed {
		xfer_state_t st;
		logic [6:0]  target_address;
		logic [7:0]  tx_remaining;
		logic [7:0]  rx_remaining;
		logic [7:0]  rx_total;
		logic        hold_bus;
		logic        event_irq_on;
		logic        buffer_irq_on;
		logic        ack_state;
	} ctx_t;

endpackage

@@ src/i2cseq_step.sv @@
module i2cseq_step (
	input  i2cseq_pkg::ctx_t                                cur,
	input  i2cseq_pkg::in_item_t                            req,
	input  logic                                            ack_enable,
	output i2cseq_pkg::ctx_t                                nxt,
	output i2cseq_pkg::out_item_t [i2cseq_pkg::MAX_RESULTS-1:0] res,
	output logic [i2cseq_pkg::CNT_W-1:0]                    res_cnt
);
	import i2cseq_pkg::*;

	logic       is_start;
	logic       is_event;
	logic       busy;
	logic       start_ok;
	logic       ev_on;
	logic       sb_hit;
	logic       addr_hit;
	logic       btf_hit;
	logic       stopf_hit;
	logic       tx_hit;
	logic       rx_hit;
	logic       rx_has;
	logic [7:0] rx_rem_new;
	logic       rx_done;
	logic       ack_a;
	logic       ack_r1;
	logic       ack_r;
	logic       ack_final;

	out_item_t                  base;
	out_item_t [MAX_RESULTS-1:0] cand;
	logic [MAX_RESULTS-1:0]     hit;
	logic [CNT_W-1:0]           idx;

	always_comb begin
		is_start  = (req.req_type == REQ_START_TX) || (req.req_type == REQ_START_RX);
		is_event  = (req.req_type == REQ_EVENT);
		busy      = (cur.st == ST_TX) || (cur.st == ST_RX);
		start_ok  = is_start && !busy;
		ev_on     = is_event && cur.event_irq_on;
		sb_hit    = ev_on && req.flag_sb && busy;
		addr_hit  = ev_on && req.flag_addr && req.master_mode && (cur.st == ST_RX)
			&& (cur.rx_total == 8'd1);
		btf_hit   = ev_on && req.flag_btf && (cur.st == ST_TX) && (cur.tx_remaining == 8'd0)
			&& req.flag_txe;
		stopf_hit = ev_on && req.flag_stopf;
		// btf needs zero remaining, so it never coincides with a data write
		tx_hit    = ev_on && cur.buffer_irq_on && req.flag_txe && req.master_mode
			&& (cur.st == ST_TX) && (cur.tx_remaining != 8'd0);
		rx_hit    = ev_on && cur.buffer_irq_on && req.flag_rxne && req.master_mode
			&& (cur.st == ST_RX);

		rx_has     = (cur.rx_total != 8'd0);
		rx_rem_new = rx_has ? (cur.rx_remaining - 8'd1) : cur.rx_remaining;
		rx_done    = (rx_rem_new == 8'd0);

		ack_a  = addr_hit ? 1'b0 : cur.ack_state;
		// nack the last byte when two remain
		ack_r1 = (rx_has && (cur.rx_total > 8'd1) && (cur.rx_remaining == 8'd2)) ? 1'b0 : ack_a;
		ack_r  = (rx_done && ack_enable) ? 1'b1 : ack_r1;
		ack_final = rx_hit ? ack_r : ack_a;
	end

	// next context
	always_comb begin
		nxt = cur;
		if (start_ok) begin
			nxt.target_address = req.dev_address;
			nxt.hold_bus       = req.repeated_start;
			if (req.req_type == REQ_START_TX) begin
				nxt.tx_remaining = req.xfer_length;
				nxt.st           = ST_TX;
			end else begin
				nxt.rx_remaining = req.xfer_length;
				nxt.rx_total     = req.xfer_length;
				nxt.st           = ST_RX;
			end
			nxt.event_irq_on  = 1'b1;
			nxt.buffer_irq_on = 1'b1;
		end else if (is_event) begin
			nxt.ack_state = ack_final;
			if (btf_hit) begin
				nxt.st            = ST_READY;
				nxt.event_irq_on  = 1'b0;
				nxt.buffer_irq_on = 1'b0;
				nxt.tx_remaining  = 8'd0;
			end
			if (tx_hit) begin
				nxt.tx_remaining = cur.tx_remaining - 8'd1;
			end
			if (rx_hit) begin
				nxt.rx_remaining = rx_rem_new;
				if (rx_done) begin
					nxt.st            = ST_READY;
					nxt.event_irq_on  = 1'b0;
					nxt.buffer_irq_on = 1'b0;
					nxt.rx_remaining  = 8'd0;
					nxt.rx_total      = 8'd0;
				end
			end
		end
	end

	// result list, packed in order sb, btf, stopf, data
	always_comb begin
		base             = '0;
		base.prev_status = cur.st;
		base.ack_bit     = cur.ack_state;

		cand[0]                = base;
		cand[0].dr_write_valid = 1'b1;
		cand[0].dr_write_value = {cur.target_address, cur.st == ST_RX};

		cand[1]            = base;
		cand[1].stop_cmd   = !cur.hold_bus;
		cand[1].event_code = EV_TX_DONE;
		cand[1].ack_bit    = ack_a;

		cand[2]            = base;
		cand[2].event_code = EV_STOPF;
		cand[2].ack_bit    = ack_a;

		cand[3] = base;
		if (tx_hit) begin
			cand[3].dr_write_valid = 1'b1;
			cand[3].dr_write_value = req.data_in;
			cand[3].ack_bit        = ack_a;
		end else begin
			cand[3].rx_valid   = rx_has;
			cand[3].rx_value   = rx_has ? req.data_in : 8'd0;
			cand[3].stop_cmd   = rx_done && !cur.hold_bus;
			cand[3].event_code = rx_done ? EV_RX_DONE : EV_NONE;
			cand[3].ack_bit    = ack_r;
		end

		hit = {tx_hit || rx_hit, stopf_hit, btf_hit, sb_hit};

		res = '0;
		idx = '0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (hit[k]) begin
				res[idx[$clog2(MAX_RESULTS)-1:0]] = cand[k];
				idx = idx + CNT_W'(1);
			end
		end
		if (idx == '0) begin
			// nothing to report: one result with start_cmd and any dropped ack
			res[0]           = base;
			res[0].start_cmd = start_ok;
			res[0].ack_bit   = ack_a;
			idx              = CNT_W'(1);
		end
		res_cnt = idx;
		res[res_cnt[$clog2(MAX_RESULTS)-1:0] - 1'b1].last = 1'b1;
	end

endmodule

@@ src/i2c_master_irq_transfer_sequencer.sv @@
// Interrupt-driven I2C master transfer sequencer. Each request (start transmit, start
// receive, or an interrupt event carrying SR1/SR2 flags and the data register) is
// evaluated in the accept cycle and turns into one to four results, held in a small
// result register file; the last result of a request has last set. A request is taken
// when no result is waiting, or when one is waiting and out_stall is low so it leaves
// in that cycle; single-result requests stream at one per cycle while out_stall stays low,
// and a request with n results stalls the input until its last one leaves. Writing ack_enable
// also loads the live ACK bit; write it only while no results are pending.
module i2c_master_irq_transfer_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  i2cseq_pkg::in_item_t in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output i2cseq_pkg::out_item_t out_data,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data
);
	import i2cseq_pkg::*;

	ctx_t                        ctx_q;
	ctx_t                        ctx_nxt;
	logic                        ack_en_q;
	out_item_t [MAX_RESULTS-1:0] res_q;
	out_item_t [MAX_RESULTS-1:0] res_new;
	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            res_cnt;
	logic                        accept;
	logic                        pop;

	i2cseq_step u_step (
		.cur        (ctx_q),
		.req        (in_data),
		.ack_enable (ack_en_q),
		.nxt        (ctx_nxt),
		.res        (res_new),
		.res_cnt    (res_cnt)
	);

	assign out_valid = (cnt_q != '0);
	assign out_data  = res_q[0];
	assign pop       = out_valid && !out_stall;
	assign in_stall  = !((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && !out_stall));
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q    <= '{st: ST_READY, ack_state: 1'b1, default: '0};
			ack_en_q <= 1'b1;
			cnt_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				ack_en_q        <= cfg_wr_data;
				ctx_q.ack_state <= cfg_wr_data;
			end else if (accept) begin
				ctx_q <= ctx_nxt;
			end
			if (accept) begin
				cnt_q <= res_cnt;
			end else if (pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// result register file, head at entry 0
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_new;
		end else if (pop) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

`ifndef ASSERT_OFF
	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !in_stall)
		else $error("request stalled with no results pending");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("result count exceeds capacity");

	a_not_last_more: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> (cnt_q > CNT_W'(1)))
		else $error("non-final result with nothing behind it");

	a_ready_irq_off: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_q.st == ST_READY) |-> (!ctx_q.event_irq_on && !ctx_q.buffer_irq_on))
		else $error("interrupts enabled while ready");
`endif

endmodule
